@@ sv/bounded_set_store_core_assert.svh @@
// Assertion macros for the bounded set store.
`ifndef BOUNDED_SET_STORE_CORE_ASSERT_SVH
`define BOUNDED_SET_STORE_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/bss_pkg.sv @@
`timescale 1ns / 1ps

package bss_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int LIMIT_W = 5;
    localparam int FIELD_W = 5;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Byte address of the capacity register on the APB port.
    localparam logic [ADDR_W-1:0] ADDR_SET_LIMIT = 3'd0;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Commit strobes that the control hands to every cell in the update cycle.
    typedef struct packed {
        logic append;
        logic remove;
    } t_cell_ctrl;

endpackage

@@ sv/bss_cell.sv @@
`timescale 1ns / 1ps

module bss_cell #(
    parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH_DEFAULT,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmp,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]       i_count,
    input  bss_pkg::t_cell_ctrl    i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_next_data,
    input  logic                   i_seen,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic                   o_match,
    output logic                   o_seen
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic                   r_match;
    logic                   w_in_use;

    assign w_in_use = IDX < i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp) begin
            r_match <= w_in_use && (r_data == i_key);
        end
    end

    // A removal pulls the neighbor's word into every cell at or after the match.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && (i_count == IDX)) begin
            r_data <= i_key;
        end else if (i_ctrl.remove && (i_seen || r_match)) begin
            r_data <= i_next_data;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_seen  = i_seen || r_match;

endmodule

@@ sv/bounded_set_store_core.sv @@
`timescale 1ns / 1ps
// Bounded set store: keeps up to DEPTH distinct values in insertion order.
// Input words carry an operation (add, remove, search) and a value; each
// accepted word yields exactly one result word with success, the 1-based
// position of the match before the operation, the element count after it
// and the empty and full flags. Both channels use valid/ready.
// An accepted word is compared in the cells, then its result is written to
// the output register by the update state; no new word is taken until then.
// The compare step broadcasts the value to the row of cells, each comparing
// its own entry; the update step encodes the first match and appends the
// value or shifts the later cells down by one.
// A result that the receiver has not taken holds the output register and
// stops further words from being accepted; a word is taken in the same
// cycle as the waiting result leaves.
// The capacity register sits at byte address 0 of the APB port and resets
// to 16. Reset empties the set; no clearing pass is needed.
module bounded_set_store_core #(
    parameter int DEPTH       = bss_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = bss_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bss_pkg::OP_W-1:0]     i_operation,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_success,
    output logic [bss_pkg::FIELD_W-1:0]  o_position,
    output logic [bss_pkg::FIELD_W-1:0]  o_element_count,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bss_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W = (CNT_W > bss_pkg::LIMIT_W) ? CNT_W : bss_pkg::LIMIT_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                         r_state;
    logic [bss_pkg::OP_W-1:0]     r_op;
    logic [VALUE_WIDTH-1:0]       r_key;
    logic [CNT_W-1:0]             r_count;
    logic [bss_pkg::LIMIT_W-1:0]  r_limit;
    logic                         r_out_valid;
    logic                         r_success;
    logic [bss_pkg::FIELD_W-1:0]  r_position;
    logic [bss_pkg::FIELD_W-1:0]  r_count_out;
    logic                         r_empty;
    logic                         r_full;

    logic [CNT_W-1:0]             n_count;
    logic                         n_success;
    logic [CNT_W-1:0]             n_position;

    logic                         w_accept;
    logic [VALUE_WIDTH-1:0]       w_in_key;
    logic [VALUE_WIDTH-1:0]       w_key;
    logic [DEPTH-1:0]             w_match;
    logic [DEPTH:0]               w_seen;
    logic [VALUE_WIDTH-1:0]       w_data [DEPTH];
    logic [IDX_W-1:0]             w_first;
    logic                         w_found;
    logic                         w_op_known;
    logic [LIM_W-1:0]             w_cap;
    logic [LIM_W-1:0]             w_count_l;
    logic                         w_add_ok;
    logic                         w_remove_ok;
    bss_pkg::t_cell_ctrl          w_ctrl;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign w_in_key = VALUE_WIDTH'($unsigned(i_value));
    // Cells compare against the incoming word; an append writes the held key.
    assign w_key    = (r_state == ST_IDLE) ? w_in_key : r_key;

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        bss_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmp       (w_accept),
            .i_key       (w_key),
            .i_count     (r_count),
            .i_ctrl      (w_ctrl),
            .i_next_data (w_next),
            .i_seen      (w_seen[g]),
            .o_data      (w_data[g]),
            .o_match     (w_match[g]),
            .o_seen      (w_seen[g+1])
        );
    end

    always_comb begin
        w_first = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_first = IDX_W'(k);
            end
        end
    end

    assign w_found    = w_seen[DEPTH];
    assign w_op_known = (r_op == bss_pkg::OP_ADD) || (r_op == bss_pkg::OP_REMOVE) ||
                        (r_op == bss_pkg::OP_SEARCH);
    assign w_cap      = (LIM_W'(r_limit) > DEPTH_L) ? DEPTH_L : LIM_W'(r_limit);
    assign w_count_l  = LIM_W'(r_count);
    assign w_add_ok   = (r_op == bss_pkg::OP_ADD) && !w_found && (w_count_l < w_cap);
    assign w_remove_ok = (r_op == bss_pkg::OP_REMOVE) && w_found;

    assign w_ctrl.append = (r_state == ST_UPD) && w_add_ok;
    assign w_ctrl.remove = (r_state == ST_UPD) && w_remove_ok;

    always_comb begin
        n_count    = r_count;
        n_success  = 1'b0;
        n_position = '0;
        if (w_op_known && w_found) begin
            n_position = CNT_W'(w_first) + 1'b1;
        end
        if (w_add_ok) begin
            n_count   = r_count + 1'b1;
            n_success = 1'b1;
        end else if (w_remove_ok) begin
            n_count   = r_count - 1'b1;
            n_success = 1'b1;
        end else if (r_op == bss_pkg::OP_SEARCH) begin
            n_success = w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_UPD;
                    end
                    if (r_out_valid && i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_UPD: begin
                    r_state     <= ST_IDLE;
                    r_count     <= n_count;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_key <= w_in_key;
        end
        if (r_state == ST_UPD) begin
            r_success   <= n_success;
            r_position  <= bss_pkg::FIELD_W'(n_position);
            r_count_out <= bss_pkg::FIELD_W'(n_count);
            r_empty     <= (n_count == '0);
            r_full      <= (LIM_W'(n_count) >= w_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bss_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == bss_pkg::ADDR_SET_LIMIT)) begin
            r_limit <= pwdata[bss_pkg::LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == bss_pkg::ADDR_SET_LIMIT) ? 32'(r_limit) : 32'd0;

    assign o_valid         = r_out_valid;
    assign o_success       = r_success;
    assign o_position      = r_position;
    assign o_element_count = r_count_out;
    assign o_is_empty      = r_empty;
    assign o_is_full       = r_full;

`include "bounded_set_store_core_assert.svh"

    `BSS_ASSERT_NEXT(a_ready_drops, w_accept, !o_ready, "ready stayed high after a word")
    `BSS_ASSERT_NEXT(a_add_counts, w_ctrl.append, r_count == $past(r_count) + 1'b1,
                     "append did not raise the count")
    `BSS_ASSERT_NEXT(a_remove_counts, w_ctrl.remove, r_count == $past(r_count) - 1'b1,
                     "removal did not lower the count")
    `BSS_ASSERT_SAME(a_count_bound, 1'b1, LIM_W'(r_count) <= DEPTH_L,
                     "count exceeds depth")

endmodule

@@ tb/bounded_set_store_core_tb.sv @@
`timescale 1ns / 1ps

module bounded_set_store_core_tb;

    localparam int SET_DEPTH       = bss_pkg::DEPTH_DEFAULT;
    localparam int POOL_SIZE       = 20;
    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 104;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIRECTED_ROWS   = 27;

    localparam logic [bss_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic                        success;
        logic [bss_pkg::FIELD_W-1:0] position;
        logic [bss_pkg::FIELD_W-1:0] element_count;
        logic                        is_empty;
        logic                        is_full;
    } t_set_result;

    typedef enum logic {ROW_WORD, ROW_LIMIT} t_row_kind;

    // For a limit row the value column holds the capacity to program.
    typedef struct packed {
        t_row_kind    kind;
        logic [1:0]   op;
        logic [31:0]  value;
        logic         typed;
        t_set_result  want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [bss_pkg::OP_W-1:0]      i_operation = bss_pkg::OP_SEARCH;
    logic signed [31:0]            i_value = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_success;
    logic [bss_pkg::FIELD_W-1:0]   o_position;
    logic [bss_pkg::FIELD_W-1:0]   o_element_count;
    logic                          o_is_empty;
    logic                          o_is_full;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bss_pkg::ADDR_W-1:0]    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // A pinned word carries its expected result from the table.
    logic                          word_pinned = 1'b0;
    t_set_result                   pinned_result = '0;

    // Mirror of the set as the predictor sees it.
    logic [31:0]                   members [SET_DEPTH];
    int unsigned                   member_count = 0;
    logic [bss_pkg::LIMIT_W-1:0]   capacity_reg = bss_pkg::LIMIT_RESET;

    t_set_result                   pending_replies [$];
    logic [31:0]                   value_pool [POOL_SIZE];

    int failures = 0;
    int idle_cycles = 0;
    int words_in = 0;
    int words_out = 0;
    int adds_done = 0;
    int removes_done = 0;
    int search_hits = 0;
    int peak_count = 0;

    int stall_left = 0;
    int stall_pct = 0;
    int mode_timer = 0;

    bounded_set_store_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_success      (o_success),
        .o_position     (o_position),
        .o_element_count(o_element_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Capacity starts at its reset value of 16. Every expected result here is
    // plain arithmetic on a handful of entries.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WORD, bss_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_RESERVED,        32'h0000_0000, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h8000_0000, 1'b1, '{1'b1, 5'd0, 5'd1, 1'b0, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h7fff_ffff, 1'b1, '{1'b1, 5'd0, 5'd2, 1'b0, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h8000_0000, 1'b1, '{1'b0, 5'd1, 5'd2, 1'b0, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_SEARCH, 32'h7fff_ffff, 1'b1, '{1'b1, 5'd2, 5'd2, 1'b0, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h0000_0000, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'hffff_ffff, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, 5'd1, 5'd3, 1'b0, 1'b0}},
        '{ROW_WORD, bss_pkg::OP_SEARCH, 32'hffff_ffff, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, '{1'b0, 5'd0, 5'd3, 1'b0, 1'b0}},
        '{ROW_WORD, OP_RESERVED,        32'h7fff_ffff, 1'b1, '{1'b0, 5'd0, 5'd3, 1'b0, 1'b0}},
        '{ROW_LIMIT, bss_pkg::OP_ADD,   32'd2,         1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h1234_5678, 1'b1, '{1'b0, 5'd0, 5'd3, 1'b0, 1'b1}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h0000_0000, 1'b1, '{1'b0, 5'd2, 5'd3, 1'b0, 1'b1}},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'hffff_ffff, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h5555_5555, 1'b1, '{1'b1, 5'd0, 5'd2, 1'b0, 1'b1}},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'haaaa_aaaa, 1'b1, '{1'b0, 5'd0, 5'd2, 1'b0, 1'b1}},
        '{ROW_LIMIT, bss_pkg::OP_ADD,   32'd0,         1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_ADD,    32'h0000_0001, 1'b1, '{1'b0, 5'd0, 5'd2, 1'b0, 1'b1}},
        '{ROW_WORD, bss_pkg::OP_SEARCH, 32'h5555_5555, 1'b0, '0},
        '{ROW_LIMIT, bss_pkg::OP_ADD,   32'd31,        1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'h7fff_ffff, 1'b0, '0},
        '{ROW_WORD, bss_pkg::OP_REMOVE, 32'h5555_5555, 1'b1, '{1'b1, 5'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_RESERVED,        32'h0000_0000, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b1, 1'b0}}
    };

    logic [bss_pkg::LIMIT_W-1:0] limit_plan [PHASES] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1,
                                                          5'd9, 5'd16, 5'd2, 5'd16};

    // Applies one word to the mirrored set and returns the result it should give.
    function automatic t_set_result apply_set_op(logic [bss_pkg::OP_W-1:0] op,
                                                 logic [31:0] val);
        t_set_result r;
        int unsigned cap;
        int unsigned hit;
        int unsigned i;
        cap = (capacity_reg > SET_DEPTH) ? SET_DEPTH : capacity_reg;
        hit = 0;
        r = '0;
        if (op != OP_RESERVED) begin
            for (i = 0; i < member_count; i++) begin
                if (hit == 0 && members[i] == val) hit = i + 1;
            end
        end
        case (op)
            bss_pkg::OP_ADD: begin
                if (hit == 0 && member_count < cap) begin
                    members[member_count] = val;
                    member_count++;
                    r.success = 1'b1;
                end
            end
            bss_pkg::OP_REMOVE: begin
                if (hit != 0) begin
                    for (i = hit - 1; i + 1 < member_count; i++) members[i] = members[i + 1];
                    member_count--;
                    r.success = 1'b1;
                end
            end
            bss_pkg::OP_SEARCH: r.success = (hit != 0);
            default: r.success = 1'b0;
        endcase
        r.position      = hit[bss_pkg::FIELD_W-1:0];
        r.element_count = member_count[bss_pkg::FIELD_W-1:0];
        r.is_empty      = (member_count == 0);
        r.is_full       = (member_count >= cap);
        return r;
    endfunction

    function automatic logic [bss_pkg::OP_W-1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return bss_pkg::OP_ADD;
        if (roll < 70) return bss_pkg::OP_REMOVE;
        if (roll < 95) return bss_pkg::OP_SEARCH;
        return OP_RESERVED;
    endfunction

    // Mostly values from a small pool or the current members, so that adds
    // collide and removes hit; the rest are free 32-bit values.
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 80 && member_count != 0) return members[$urandom_range(0, member_count - 1)];
        return $urandom;
    endfunction

    task automatic send_word(input logic [bss_pkg::OP_W-1:0] op, input logic [31:0] val,
                             input logic pin, input t_set_result want);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_value       <= val;
        word_pinned   <= pin;
        pinned_result <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Writes the capacity register once the block has gone quiet.
    task automatic program_limit(input logic [bss_pkg::LIMIT_W-1:0] lim);
        i_valid <= 1'b0;
        wait_drained();
        repeat (3) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bss_pkg::ADDR_SET_LIMIT;
        pwdata  <= {{(32 - bss_pkg::LIMIT_W){1'b0}}, lim};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_reg = lim;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: stall density switches at random between none, light and heavy,
    // so some stretches have no stalls at all.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 12);
        end
        if (mode_timer == 0) begin
            mode_timer <= $urandom_range(100, 400);
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                default: stall_pct <= 45;
            endcase
        end else begin
            mode_timer <= mode_timer - 1;
        end
    end

    // Predicts on accepted words, checks accepted results, and watches for hangs.
    always @(posedge i_clk) begin
        t_set_result seen;
        t_set_result want;
        t_set_result predicted;
        logic        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                moved = 1'b1;
                words_out++;
                seen = '{o_success, o_position, o_element_count, o_is_empty, o_is_full};
                if (pending_replies.size() == 0) begin
                    $error("result word with nothing expected");
                    failures++;
                end else begin
                    want = pending_replies.pop_front();
                    if (seen.success !== want.success) begin
                        $error("success: expected %0d, got %0d", want.success, seen.success);
                        failures++;
                    end
                    if (seen.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, seen.position);
                        failures++;
                    end
                    if (seen.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, seen.element_count);
                        failures++;
                    end
                    if (seen.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, seen.is_empty);
                        failures++;
                    end
                    if (seen.is_full !== want.is_full) begin
                        $error("is_full: expected %0d, got %0d", want.is_full, seen.is_full);
                        failures++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                moved = 1'b1;
                words_in++;
                predicted = apply_set_op(i_operation, i_value);
                if (predicted.success && i_operation == bss_pkg::OP_ADD) adds_done++;
                if (predicted.success && i_operation == bss_pkg::OP_REMOVE) removes_done++;
                if (predicted.success && i_operation == bss_pkg::OP_SEARCH) search_hits++;
                if (member_count > peak_count) peak_count = member_count;
                pending_replies.push_back(word_pinned ? pinned_result : predicted);
            end
            if (psel && penable && pwrite && pready) moved = 1'b1;
        end
        if (moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int burst_left;
        int gap;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7fff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int p = 5; p < POOL_SIZE; p++) value_pool[p] = $urandom;
        burst_left = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_LIMIT) begin
                program_limit(directed_rows[n].value[bss_pkg::LIMIT_W-1:0]);
            end else begin
                send_word(directed_rows[n].op, directed_rows[n].value,
                          directed_rows[n].typed, directed_rows[n].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            program_limit(limit_plan[ph]);
            burst_left = 0;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // Once in the run the sender holds off until the set has answered
                // every word in flight.
                if (ph == 2 && k == WORDS_PER_PHASE / 2) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end else if (burst_left == 0) begin
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                    if (gap != 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                if (burst_left != 0) burst_left--;
                send_word(pick_op(), pick_value(), 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d result words never arrived", pending_replies.size());
            failures++;
        end
        $display("Sent %0d words and checked %0d results over %0d capacity settings.",
                 words_in, words_out, PHASES + 3);
        $display("Adds %0d, removes %0d, search hits %0d, largest set %0d entries.",
                 adds_done, removes_done, search_hits, peak_count);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
